// ===== rtl/ptt_pkg.sv =====
// shared constants, request codes and the token type for the periodic timer table
package ptt_pkg;

    localparam int SLOTS       = 16;
    localparam int COUNT_WIDTH = 32;
    localparam int IDX_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SEL_W       = (IDX_W > 4) ? IDX_W : 4;
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 48;

    typedef enum logic [2:0] {
        REQ_TICK       = 3'd0,
        REQ_CREATE     = 3'd1,
        REQ_DELETE     = 3'd2,
        REQ_SET_PERIOD = 3'd3,
        REQ_SCAN       = 3'd4
    } req_t;

    typedef logic [IDX_W-1:0]       slot_idx_t;
    typedef logic [COUNT_WIDTH-1:0] count_t;

    // request token that walks the row of slot cells, one cell per cycle
    typedef struct packed {
        logic      valid;
        logic [2:0] req;
        logic [3:0] sidx;
        count_t    per;
        slot_idx_t scan_pos;
        slot_idx_t pos;
        logic      found;
        slot_idx_t slot;
        logic      dvalid;
    } token_t;

    // addressed slot match, out-of-range indexes never hit
    function automatic logic slot_hit(slot_idx_t pos, logic [3:0] sidx);
        return SEL_W'(pos) == SEL_W'(sidx);
    endfunction

endpackage

// ===== rtl/ptt_cell.sv =====
// one timer slot cell: holds a slot's state and applies the passing request to it
module ptt_cell (
    input  logic            aclk,
    input  logic            aresetn,
    input  ptt_pkg::token_t tok_in,
    output ptt_pkg::token_t tok_out
);
    import ptt_pkg::*;

    logic   in_use_reg, in_use_next;
    logic   ready_reg, ready_next;
    count_t period_reg, period_next;
    count_t count_reg, count_next;
    count_t count_inc;
    token_t tok_reg, tok_next;

    assign count_inc = count_reg + 1'b1;

    // apply the request to this slot and update the token
    always_comb begin
        in_use_next  = in_use_reg;
        ready_next   = ready_reg;
        period_next  = period_reg;
        count_next   = count_reg;
        tok_next     = tok_in;
        tok_next.pos = tok_in.pos + 1'b1;
        if (tok_in.valid) begin
            case (tok_in.req)
                REQ_TICK: begin
                    if (in_use_reg && !ready_reg) begin
                        if (count_inc >= period_reg) begin
                            count_next = '0;
                            ready_next = 1'b1;
                        end else begin
                            count_next = count_inc;
                        end
                    end
                end
                REQ_CREATE: begin
                    if (!tok_in.found && !in_use_reg) begin
                        in_use_next    = 1'b1;
                        period_next    = tok_in.per;
                        tok_next.found = 1'b1;
                        tok_next.slot  = tok_in.pos;
                    end
                end
                REQ_DELETE: begin
                    if (slot_hit(tok_in.pos, tok_in.sidx)) begin
                        in_use_next = 1'b0;
                        ready_next  = 1'b0;
                        count_next  = '0;
                    end
                end
                REQ_SET_PERIOD: begin
                    if (slot_hit(tok_in.pos, tok_in.sidx)) begin
                        ready_next  = 1'b0;
                        period_next = tok_in.per;
                        count_next  = '0;
                    end
                end
                REQ_SCAN: begin
                    if (tok_in.pos == tok_in.scan_pos && ready_reg) begin
                        ready_next      = 1'b0;
                        tok_next.dvalid = 1'b1;
                        tok_next.slot   = tok_in.pos;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // slot flags, counter and token stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_use_reg    <= 1'b0;
            ready_reg     <= 1'b0;
            count_reg     <= '0;
            tok_reg.valid <= 1'b0;
        end else begin
            in_use_reg <= in_use_next;
            ready_reg  <= ready_next;
            count_reg  <= count_next;
            tok_reg    <= tok_next;
        end
    end

    // period is only read after create has written it
    always_ff @(posedge aclk) begin
        period_reg <= period_next;
    end

    assign tok_out = tok_reg;

endmodule

// ===== rtl/periodic_task_timer_table.sv =====
// top level of the periodic timer table: request entry, cell row and result queue
//
// Usage:
//   Requests enter on the s_axis channel, results leave on m_axis, one result
//   per request. A request is taken when s_axis_tvalid and s_axis_tready are
//   both high; a result is taken when m_axis_tvalid and m_axis_tready are high.
//   A request walks the row of SLOTS slot cells, one cell per cycle, and
//   its result enters the result queue as it leaves the last cell.
//   Only one request is in the cell row at a time; a new request can enter
//   cell 0 in the cycle in which the previous one leaves the last cell,
//   as long as the result queue has room for its result.
//   A two-entry result queue lets the next request start while a result
//   still waits; s_axis_tready drops once the queue would hold two results.
//   Reset (aresetn low at a clock edge) frees all slots, clears ready flags,
//   counters, the scan position and the global tick count, and empties the
//   queue. When the receiver stalls, the head result and its tvalid hold.
module periodic_task_timer_table (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // req_type[2:0], slot_index[6:3], period[38:7], zero [39]
    input  logic [ptt_pkg::S_TDATA_W-1:0] s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // status[0], created_slot[4:1], dispatch_valid[5], dispatch_slot[9:6],
    // tick_count[41:10], zero [47:42]
    output logic [ptt_pkg::M_TDATA_W-1:0] m_axis_tdata
);
    import ptt_pkg::*;

    token_t                 chain [SLOTS+1];
    token_t                 head_tok;
    token_t                 last_tok;
    logic                   s_accept;
    logic [2:0]             s_req;
    logic                   busy_reg, busy_next;
    slot_idx_t              scan_pos_reg, scan_pos_next;
    logic [31:0]            ticks_reg, ticks_next;
    logic [M_TDATA_W-1:0]   fifo_mem_reg [2];
    logic                   wr_ptr_reg, wr_ptr_next;
    logic                   rd_ptr_reg, rd_ptr_next;
    logic [1:0]             cnt_reg, cnt_next;
    logic                   push, pop;
    logic                   res_status;
    logic [3:0]             res_created, res_dslot;
    logic [M_TDATA_W-1:0]   res_word;

    assign s_req    = s_axis_tdata[2:0];
    assign s_accept = s_axis_tvalid && s_axis_tready;
    assign last_tok = chain[SLOTS];
    assign push     = last_tok.valid;
    assign pop      = m_axis_tvalid && m_axis_tready;

    // request token entering the first cell
    always_comb begin
        head_tok          = '0;
        head_tok.valid    = s_accept;
        head_tok.req      = s_req;
        head_tok.sidx     = s_axis_tdata[6:3];
        head_tok.per      = COUNT_WIDTH'(s_axis_tdata[38:7]);
        head_tok.scan_pos = scan_pos_reg;
    end

    assign chain[0] = head_tok;

    // row of slot cells
    for (genvar k = 0; k < SLOTS; k++) begin : g_cell
        ptt_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .tok_in  (chain[k]),
            .tok_out (chain[k+1])
        );
    end

    // one request in the row at a time, room kept for its result
    always_comb begin
        cnt_next      = cnt_reg + {1'b0, push} - {1'b0, pop};
        s_axis_tready = (!busy_reg || last_tok.valid) && (cnt_next != 2'd2);
        busy_next     = s_accept ? 1'b1 : (last_tok.valid ? 1'b0 : busy_reg);
        wr_ptr_next   = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next   = pop ? ~rd_ptr_reg : rd_ptr_reg;
    end

    // scan position and global tick count, updated as a request is taken
    always_comb begin
        scan_pos_next = scan_pos_reg;
        ticks_next    = ticks_reg;
        if (s_accept && s_req == REQ_SCAN) begin
            scan_pos_next = (scan_pos_reg == IDX_W'(SLOTS - 1)) ? '0 : scan_pos_reg + 1'b1;
        end
        if (s_accept && s_req == REQ_TICK) begin
            ticks_next = ticks_reg + 32'd1;
        end
    end

    // result word from the token leaving the last cell
    always_comb begin
        res_status  = (last_tok.req == REQ_CREATE) && !last_tok.found;
        res_created = ((last_tok.req == REQ_CREATE) && last_tok.found) ?
                      4'(last_tok.slot) : 4'd0;
        res_dslot   = last_tok.dvalid ? 4'(last_tok.slot) : 4'd0;
        res_word    = {6'd0, ticks_reg, res_dslot, last_tok.dvalid, res_created,
                       res_status};
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            scan_pos_reg <= '0;
            ticks_reg    <= '0;
            wr_ptr_reg   <= 1'b0;
            rd_ptr_reg   <= 1'b0;
            cnt_reg      <= 2'd0;
        end else begin
            busy_reg     <= busy_next;
            scan_pos_reg <= scan_pos_next;
            ticks_reg    <= ticks_next;
            wr_ptr_reg   <= wr_ptr_next;
            rd_ptr_reg   <= rd_ptr_next;
            cnt_reg      <= cnt_next;
        end
    end

    // result queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_mem_reg[wr_ptr_reg] <= res_word;
        end
    end

    assign m_axis_tvalid = (cnt_reg != 2'd0);
    assign m_axis_tdata  = fifo_mem_reg[rd_ptr_reg];

endmodule

// ===== rtl/ptt_checker.sv =====
// port-level checks for the periodic timer table and their bind
module ptt_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [ptt_pkg::M_TDATA_W-1:0] m_axis_tdata
);
    import ptt_pkg::*;

    // stalled result keeps its valid
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result valid dropped while stalled");

    // stalled result keeps its data
    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result data changed while stalled");

    // a dispatch never carries create status or a created slot
    a_dispatch_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[5] |-> m_axis_tdata[4:0] == 5'd0)
        else $error("dispatch result mixed with create fields");

    // a full table report carries no slot and no dispatch
    a_full_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[9:1] == 9'd0)
        else $error("full table report carries slot fields");

endmodule

bind periodic_task_timer_table ptt_checker u_ptt_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== bench/tb_periodic_task_timer_table.sv =====
// testbench for the periodic timer table: directed table, random requests, scoreboard check
`timescale 1ns / 100ps

module tb_periodic_task_timer_table;
    import ptt_pkg::*;

    // request codes above the scan code do nothing
    localparam logic [2:0] REQ_RESERVED_FIRST = 3'd5;
    localparam logic [2:0] REQ_RESERVED_MID   = 3'd6;
    localparam logic [2:0] REQ_RESERVED_LAST  = 3'd7;

    localparam int N_RANDOM     = 2000;
    localparam int PHASE_LEN    = 250;
    localparam int QUIET_FROM   = 1700;
    localparam int HOLD_AT      = 600;
    localparam int HOLD_CYCLES  = 400;
    localparam int PAUSE_AT     = 1200;
    localparam int DRAIN_CYCLES = 2 * SLOTS + 8;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int N_DIRECTED   = 23;

    // one result, packed so that the struct lines up with m_axis_tdata[41:0]
    typedef struct packed {
        logic [31:0] ticks;
        logic [3:0]  dslot;
        logic        dvalid;
        logic [3:0]  created;
        logic        status;
    } timer_result_t;

    // one row of the directed table
    typedef struct packed {
        logic [2:0]    req;
        logic [3:0]    idx;
        logic [31:0]   per;
        logic          has_typed;
        timer_result_t typed_res;
    } timer_req_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;

    periodic_task_timer_table dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // shadow copy of the slot table
    logic        slot_used  [SLOTS];
    logic        slot_ready [SLOTS];
    count_t      slot_per   [SLOTS];
    count_t      slot_cnt   [SLOTS];
    int          scan_ptr;
    logic [31:0] tick_total;

    timer_result_t  expected_results[$];
    timer_req_row_t directed_rows[N_DIRECTED];
    timer_result_t  want;
    timer_result_t  got;

    int  errors = 0;
    int  cycle_cnt = 0;
    int  req_seen[8];
    int  n_dispatch = 0;
    int  n_full = 0;
    int  n_results = 0;
    bit  tx_idle_en = 1'b1;
    bit  rx_idle_en = 1'b1;
    bit  hold_req = 1'b0;
    bit  hold_done = 1'b0;

    // apply one request to the shadow table and return its result
    function automatic timer_result_t advance_timer_table(logic [2:0] req, logic [3:0] idx,
                                                          logic [31:0] per);
        timer_result_t res;
        count_t        nxt;
        res = '0;
        case (req)
            REQ_TICK: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (slot_used[i] && !slot_ready[i]) begin
                        nxt = slot_cnt[i] + 1'b1;
                        if (nxt >= slot_per[i]) begin
                            nxt = '0;
                            slot_ready[i] = 1'b1;
                        end
                        slot_cnt[i] = nxt;
                    end
                end
                tick_total = tick_total + 1;
            end
            REQ_CREATE: begin
                res.status = 1'b1;
                for (int i = 0; i < SLOTS; i++) begin
                    if (res.status && !slot_used[i]) begin
                        slot_used[i] = 1'b1;
                        slot_per[i]  = count_t'(per);
                        res.status   = 1'b0;
                        res.created  = 4'(i);
                    end
                end
            end
            REQ_DELETE: begin
                if (int'(idx) < SLOTS) begin
                    slot_used[idx]  = 1'b0;
                    slot_ready[idx] = 1'b0;
                    slot_cnt[idx]   = '0;
                end
            end
            REQ_SET_PERIOD: begin
                if (int'(idx) < SLOTS) begin
                    slot_ready[idx] = 1'b0;
                    slot_per[idx]   = count_t'(per);
                    slot_cnt[idx]   = '0;
                end
            end
            REQ_SCAN: begin
                if (scan_ptr >= SLOTS) scan_ptr = 0;
                if (slot_ready[scan_ptr]) begin
                    res.dvalid = 1'b1;
                    res.dslot  = 4'(scan_ptr);
                    slot_ready[scan_ptr] = 1'b0;
                end
                scan_ptr = scan_ptr + 1;
                if (scan_ptr >= SLOTS) scan_ptr = 0;
            end
            default: ;
        endcase
        res.ticks = tick_total;
        return res;
    endfunction

    function automatic timer_req_row_t plain_row(logic [2:0] req, logic [3:0] idx,
                                                 logic [31:0] per);
        timer_req_row_t row;
        row = '0;
        row.req = req;
        row.idx = idx;
        row.per = per;
        return row;
    endfunction

    function automatic timer_req_row_t typed_row(logic [2:0] req, logic [3:0] idx,
                                                 logic [31:0] per, logic st, logic [3:0] cs,
                                                 logic dv, logic [3:0] ds, logic [31:0] tk);
        timer_req_row_t row;
        row = plain_row(req, idx, per);
        row.has_typed = 1'b1;
        row.typed_res = '{ticks: tk, dslot: ds, dvalid: dv, created: cs, status: st};
        return row;
    endfunction

    // offer one request, wait for the handshake, then record what it should return
    task automatic offer_request(input logic [2:0] req, input logic [3:0] idx,
                                 input logic [31:0] per, input logic has_typed,
                                 input timer_result_t typed_res);
        timer_result_t res;
        @(negedge aclk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, per, idx, req};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        res = advance_timer_table(req, idx, per);
        expected_results.push_back(has_typed ? typed_res : res);
        req_seen[req]++;
    endtask

    // random request, weighted by the current phase
    task automatic pick_request(input int mode, output logic [2:0] req,
                                output logic [3:0] idx, output logic [31:0] per);
        int r;
        int pr;
        int t_tick, t_create, t_delete, t_set, t_scan;
        case (mode)
            1:       begin t_tick = 15; t_create = 65; t_delete = 68; t_set = 75; t_scan = 95; end
            2:       begin t_tick = 45; t_create = 50; t_delete = 55; t_set = 60; t_scan = 98; end
            3:       begin t_tick = 25; t_create = 45; t_delete = 70; t_set = 85; t_scan = 97; end
            default: begin t_tick = 30; t_create = 45; t_delete = 55; t_set = 65; t_scan = 95; end
        endcase
        r = $urandom_range(0, 99);
        if (r < t_tick)        req = REQ_TICK;
        else if (r < t_create) req = REQ_CREATE;
        else if (r < t_delete) req = REQ_DELETE;
        else if (r < t_set)    req = REQ_SET_PERIOD;
        else if (r < t_scan)   req = REQ_SCAN;
        else                   req = 3'($urandom_range(REQ_RESERVED_FIRST, REQ_RESERVED_LAST));
        idx = 4'($urandom_range(0, 15));
        // mostly short periods so slots fire often, some wide and extreme ones
        pr = $urandom_range(0, 99);
        if (pr < 55)      per = $urandom_range(0, 4);
        else if (pr < 75) per = $urandom_range(5, 40);
        else if (pr < 88) per = $urandom;
        else if (pr < 94) per = '0;
        else              per = 32'hFFFF_FFFF;
    endtask

    task automatic check_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (want_v !== got_v) begin
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, want_v, got_v);
            errors++;
        end
    endtask

    // run limit
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("%0t ns: timeout, %0d results still outstanding",
                     $time, expected_results.size());
            $display("** periodic_task_timer_table: FAILED **");
            $finish;
        end
    end

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = timer_result_t'(m_axis_tdata[41:0]);
            n_results++;
            if (got.dvalid) n_dispatch++;
            if (got.status) n_full++;
            if (expected_results.size() == 0) begin
                $display("%0t ns: unexpected result, expected none, actual 0x%0h",
                         $time, m_axis_tdata);
                errors++;
            end else begin
                want = expected_results.pop_front();
                check_field("status", 32'(want.status), 32'(got.status));
                check_field("created_slot", 32'(want.created), 32'(got.created));
                check_field("dispatch_valid", 32'(want.dvalid), 32'(got.dvalid));
                check_field("dispatch_slot", 32'(want.dslot), 32'(got.dslot));
                check_field("tick_count", want.ticks, got.ticks);
                check_field("tdata padding", 32'd0, 32'(m_axis_tdata[M_TDATA_W-1:42]));
            end
        end
    end

    // result side: random stalls, one long hold-off
    initial begin
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_done) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
                hold_done = 1'b1;
            end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 11) - 1) @(negedge aclk);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // request side
    initial begin
        logic [2:0]  req;
        logic [3:0]  idx;
        logic [31:0] per;
        int          mode;

        for (int i = 0; i < SLOTS; i++) begin
            slot_used[i]  = 1'b0;
            slot_ready[i] = 1'b0;
            slot_per[i]   = '0;
            slot_cnt[i]   = '0;
        end
        scan_ptr   = 0;
        tick_total = '0;
        for (int i = 0; i < 8; i++) req_seen[i] = 0;

        // directed table: extremes, every request and the corner cases
        directed_rows[0]  = typed_row(REQ_TICK, 4'd0, 32'd0, 1'b0, 4'd0, 1'b0, 4'd0, 32'd1);
        // zero period and full-width period
        directed_rows[1]  = typed_row(REQ_CREATE, 4'd0, 32'd0, 1'b0, 4'd0, 1'b0, 4'd0, 32'd1);
        directed_rows[2]  = typed_row(REQ_CREATE, 4'd15, 32'hFFFF_FFFF,
                                      1'b0, 4'd1, 1'b0, 4'd0, 32'd1);
        directed_rows[3]  = typed_row(REQ_CREATE, 4'd0, 32'd1, 1'b0, 4'd2, 1'b0, 4'd0, 32'd1);
        directed_rows[4]  = typed_row(REQ_TICK, 4'd0, 32'd0, 1'b0, 4'd0, 1'b0, 4'd0, 32'd2);
        directed_rows[5]  = typed_row(REQ_SCAN, 4'd0, 32'd0, 1'b0, 4'd0, 1'b1, 4'd0, 32'd2);
        directed_rows[6]  = typed_row(REQ_SCAN, 4'd0, 32'd0, 1'b0, 4'd0, 1'b0, 4'd0, 32'd2);
        directed_rows[7]  = typed_row(REQ_SCAN, 4'd0, 32'd0, 1'b0, 4'd0, 1'b1, 4'd2, 32'd2);
        // set period on an unused slot, delete of used and unused slots
        directed_rows[8]  = plain_row(REQ_SET_PERIOD, 4'd15, 32'd3);
        directed_rows[9]  = plain_row(REQ_DELETE, 4'd1, 32'd0);
        directed_rows[10] = plain_row(REQ_DELETE, 4'd15, 32'd0);
        directed_rows[11] = plain_row(REQ_CREATE, 4'd0, 32'd2);
        // unknown request codes
        directed_rows[12] = plain_row(REQ_RESERVED_FIRST, 4'd3, 32'd5);
        directed_rows[13] = plain_row(REQ_RESERVED_LAST, 4'd15, 32'hFFFF_FFFF);
        directed_rows[14] = plain_row(REQ_RESERVED_MID, 4'd0, 32'h8000_0001);
        directed_rows[15] = plain_row(REQ_TICK, 4'd0, 32'd0);
        // set period clears a ready slot
        directed_rows[16] = plain_row(REQ_SET_PERIOD, 4'd0, 32'hFFFF_FFFF);
        directed_rows[17] = plain_row(REQ_SET_PERIOD, 4'd2, 32'd0);
        directed_rows[18] = plain_row(REQ_TICK, 4'd0, 32'd0);
        directed_rows[19] = plain_row(REQ_SCAN, 4'd0, 32'd0);
        // delete of a ready slot drops its dispatch
        directed_rows[20] = plain_row(REQ_DELETE, 4'd2, 32'd0);
        directed_rows[21] = plain_row(REQ_TICK, 4'd0, 32'd0);
        directed_rows[22] = plain_row(REQ_SCAN, 4'd5, 32'h7FFF_FFFE);

        // hold reset, then release it at a falling clock edge
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            offer_request(directed_rows[i].req, directed_rows[i].idx, directed_rows[i].per,
                          directed_rows[i].has_typed, directed_rows[i].typed_res);
        end

        // random part in phases of different request mixes and idling
        for (int n = 0; n < N_RANDOM; n++) begin
            mode = (n / PHASE_LEN) % 4;
            if (n >= QUIET_FROM) begin
                mode       = 0;
                tx_idle_en = 1'b0;
                rx_idle_en = 1'b0;
            end else begin
                tx_idle_en = ((n / PHASE_LEN) % 3) != 2;
                rx_idle_en = ((n / PHASE_LEN) % 3) != 1;
            end

            // sender pause until every request has come back
            if (n == PAUSE_AT) begin
                @(negedge aclk);
                s_axis_tvalid <= 1'b0;
                while (expected_results.size() != 0) @(posedge aclk);
            end
            if (n == HOLD_AT) hold_req = 1'b1;

            pick_request(mode, req, idx, per);
            offer_request(req, idx, per, 1'b0, '0);

            // idle gap, none while the receiver holds off
            if (tx_idle_en && !(hold_req && !hold_done) && $urandom_range(0, 5) == 0) begin
                @(negedge aclk);
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 11) - 1) @(negedge aclk);
            end
        end
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;

        // let the last results out, then watch for strays
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("run: %0d results checked; %0d tick, %0d create, %0d delete, %0d set-period,",
                 n_results, req_seen[REQ_TICK], req_seen[REQ_CREATE], req_seen[REQ_DELETE],
                 req_seen[REQ_SET_PERIOD]);
        $display("     %0d scan, %0d unknown; %0d dispatches, %0d creates on a full table",
                 req_seen[REQ_SCAN],
                 req_seen[REQ_RESERVED_FIRST] + req_seen[REQ_RESERVED_MID]
                     + req_seen[REQ_RESERVED_LAST],
                 n_dispatch, n_full);
        if (errors == 0) begin
            $display("** periodic_task_timer_table: PASSED **");
        end else begin
            $display("** periodic_task_timer_table: FAILED **");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/ptt_pkg.sv
rtl/ptt_cell.sv
rtl/periodic_task_timer_table.sv
rtl/ptt_checker.sv
bench/tb_periodic_task_timer_table.sv
